@@ rtl/p1305_pkg.sv @@
package p1305_pkg;

   localparam int LIMB_W  = 26;
   localparam int ACC_W   = 27;
   localparam int H_W     = 28;
   localparam int COEF_W  = 29;
   localparam int PROD_W  = H_W + COEF_W;
   localparam int SUM_W   = 61;
   localparam int CARRY_W = SUM_W - LIMB_W;
   localparam int NLIMB   = 5;

   localparam logic [63:0] R_CLAMP_LOW  = 64'h0ffffffc0fffffff;
   localparam logic [63:0] R_CLAMP_HIGH = 64'h0ffffffc0ffffffc;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   // register indexes on the configuration port
   localparam logic [1:0] REG_R_LOW  = 2'd0;
   localparam logic [1:0] REG_R_HIGH = 2'd1;
   localparam logic [1:0] REG_S_LOW  = 2'd2;
   localparam logic [1:0] REG_S_HIGH = 2'd3;

   typedef struct packed {
      logic [63:0] message_low;
      logic [63:0] message_high;
      logic [4:0]  byte_count;
      logic        last_block;
   } req_type;

   typedef struct packed {
      logic [63:0] tag_low;
      logic [63:0] tag_high;
   } rsp_type;

   // command to the shared multiply-accumulate unit
   typedef struct packed {
      logic              clear;
      logic              issue;
      logic              first;
      logic [H_W-1:0]    a;
      logic [COEF_W-1:0] b;
   } mac_cmd_type;

endpackage

@@ rtl/poly1305_mac_accumulator_top.sv @@
// Each block runs 25 products on the one shared 28x29 multiplier, then a drain
// and a fold; an empty last block skips them. A last block then runs the finish
// states (carry, select, low add, high add) before the tag sits in the output
// register. A new block is taken only once the previous one is through.
// Reset clears the key registers, the accumulator and all handshake state.
module poly1305_mac_accumulator_top (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  p1305_pkg::req_type                  req_data,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output p1305_pkg::rsp_type                  rsp_data,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [p1305_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [p1305_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [p1305_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready
);

   localparam int LW = p1305_pkg::LIMB_W;
   localparam int AW = p1305_pkg::ACC_W;
   localparam int HW = p1305_pkg::H_W;
   localparam int CW = p1305_pkg::COEF_W;
   localparam int SW = p1305_pkg::SUM_W;
   localparam int KW = p1305_pkg::CARRY_W;
   localparam int NL = p1305_pkg::NLIMB;

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MUL    = 3'd1;
   localparam logic [2:0] ST_DRAIN  = 3'd2;
   localparam logic [2:0] ST_FOLD   = 3'd3;
   localparam logic [2:0] ST_FCARRY = 3'd4;
   localparam logic [2:0] ST_FSEL   = 3'd5;
   localparam logic [2:0] ST_FLO    = 3'd6;
   localparam logic [2:0] ST_FHI    = 3'd7;

   localparam logic [2:0] LAST_LIMB = 3'(NL - 1);

   // ---------------------------------------------------------------------
   // Key registers on the configuration port
   // ---------------------------------------------------------------------
   logic [63:0] r_low_ff, r_low_in;
   logic [63:0] r_high_ff, r_high_in;
   logic [63:0] s_low_ff, s_low_in;
   logic [63:0] s_high_ff, s_high_in;
   logic        csr_wr;
   logic [1:0]  csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = paddr[4:3];

   always_comb begin
      r_low_in  = r_low_ff;
      r_high_in = r_high_ff;
      s_low_in  = s_low_ff;
      s_high_in = s_high_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            p1305_pkg::REG_R_LOW:  r_low_in  = pwdata;
            p1305_pkg::REG_R_HIGH: r_high_in = pwdata;
            p1305_pkg::REG_S_LOW:  s_low_in  = pwdata;
            p1305_pkg::REG_S_HIGH: s_high_in = pwdata;
            default:               r_low_in  = r_low_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         p1305_pkg::REG_R_LOW:  prdata = r_low_ff;
         p1305_pkg::REG_R_HIGH: prdata = r_high_ff;
         p1305_pkg::REG_S_LOW:  prdata = s_low_ff;
         p1305_pkg::REG_S_HIGH: prdata = s_high_ff;
         default:               prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Clamped r split into limbs, and the 5*r limbs that fold the wrap
   // of 2^130 back to the bottom
   // ---------------------------------------------------------------------
   logic [63:0]   r_cl_low, r_cl_high;
   logic [LW-1:0] r_limb [NL];
   logic [CW-1:0] s_limb [NL];

   assign r_cl_low  = r_low_ff & p1305_pkg::R_CLAMP_LOW;
   assign r_cl_high = r_high_ff & p1305_pkg::R_CLAMP_HIGH;

   always_comb begin
      r_limb[0] = r_cl_low[25:0];
      r_limb[1] = r_cl_low[51:26];
      r_limb[2] = {r_cl_high[13:0], r_cl_low[63:52]};
      r_limb[3] = r_cl_high[39:14];
      r_limb[4] = LW'(r_cl_high[63:40]);
      for (int k = 0; k < NL; k++) begin
         s_limb[k] = {r_limb[k], 2'b00} + CW'(r_limb[k]);
      end
   end

   // ---------------------------------------------------------------------
   // Block padding on transfer: keep bytes below the count, put 0x01 at
   // the count, zero above; a full block gets the 2^128 bit instead
   // ---------------------------------------------------------------------
   logic [127:0]  msg_raw, msg_pad;
   logic          blk_full;
   logic          blk_skip;
   logic [LW-1:0] m_limb [NL];

   assign msg_raw  = {req_data.message_high, req_data.message_low};
   assign blk_full = ~req_data.last_block | (req_data.byte_count >= 5'd16);
   assign blk_skip = req_data.last_block & (req_data.byte_count == 5'd0);

   always_comb begin
      for (int b = 0; b < 16; b++) begin
         if (blk_full || (5'(b) < req_data.byte_count)) begin
            msg_pad[8*b +: 8] = msg_raw[8*b +: 8];
         end else if (5'(b) == req_data.byte_count) begin
            msg_pad[8*b +: 8] = 8'h01;
         end else begin
            msg_pad[8*b +: 8] = 8'h00;
         end
      end
      m_limb[0] = msg_pad[25:0];
      m_limb[1] = msg_pad[51:26];
      m_limb[2] = msg_pad[77:52];
      m_limb[3] = msg_pad[103:78];
      m_limb[4] = {1'b0, blk_full, msg_pad[127:104]};
   end

   // ---------------------------------------------------------------------
   // Sequencer and datapath registers
   // ---------------------------------------------------------------------
   logic [2:0]    state_ff, state_in;
   logic [2:0]    row_ff, row_in;
   logic [2:0]    col_ff, col_in;
   logic          last_ff, last_in;
   logic [AW-1:0] acc_ff [NL];
   logic [AW-1:0] acc_in [NL];
   logic [HW-1:0] h_ff [NL];
   logic [HW-1:0] h_in [NL];
   logic [LW-1:0] dl_ff [NL-1];
   logic [LW-1:0] dl_in [NL-1];
   logic [AW-1:0] fin_ff [NL];
   logic [AW-1:0] fin_in [NL];
   logic [63:0]   lo_ff, lo_in;
   logic [63:0]   hi_ff, hi_in;
   logic [63:0]   tlo_ff, tlo_in;
   logic          tc_ff, tc_in;
   logic          rsp_valid_ff, rsp_valid_in;
   p1305_pkg::rsp_type rsp_ff, rsp_in;

   p1305_pkg::mac_cmd_type mac_cmd;
   logic [SW-1:0]          mac_sum;
   logic                   mac_row_start;

   p1305_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .cmd       (mac_cmd),
      .sum       (mac_sum),
      .row_start (mac_row_start)
   );

   // operand coefficient: r[row-col] on and below the diagonal (row >= col), 5*r above
   logic [2:0]    coef_idx;
   logic [CW-1:0] coef;

   always_comb begin
      if (row_ff >= col_ff) begin
         coef_idx = row_ff - col_ff;
         coef     = CW'(r_limb[coef_idx]);
      end else begin
         coef_idx = row_ff + 3'(NL) - col_ff;
         coef     = s_limb[coef_idx];
      end
   end

   // fold of the top carry and the final-reduction helpers
   logic [KW-1:0]   top_carry;
   logic [KW+2:0]   fold0;
   logic [HW-1:0]   fc2, fc3, fc4, fc0;
   logic [AW-1:0]   fc1;
   logic [AW-1:0]   g0s;
   logic [HW-1:0]   g1s, g2s, g3s, g4s, g4;
   logic            use_g;
   logic [AW-1:0]   sel [NL];
   logic [64:0]     tsum_lo;
   logic            slot_free;

   assign top_carry = mac_sum[SW-1:LW];
   assign fold0     = (KW+3)'(dl_ff[0]) + (KW+3)'({top_carry, 2'b00}) + (KW+3)'(top_carry);

   always_comb begin
      // carry the partly reduced accumulator through once, wrap top times 5
      fc2 = HW'(acc_ff[2]) + HW'(acc_ff[1][AW-1:LW]);
      fc3 = HW'(acc_ff[3]) + HW'(fc2[HW-1:LW]);
      fc4 = HW'(acc_ff[4]) + HW'(fc3[HW-1:LW]);
      fc0 = HW'(acc_ff[0]) + HW'({fc4[HW-1:LW], 2'b00}) + HW'(fc4[HW-1:LW]);
      fc1 = AW'(acc_ff[1][LW-1:0]) + AW'(fc0[HW-1:LW]);

      // h + 5 - 2^130; take it when not negative
      g0s   = AW'(fin_ff[0]) + AW'(5);
      g1s   = HW'(fin_ff[1]) + HW'(g0s[AW-1:LW]);
      g2s   = HW'(fin_ff[2]) + HW'(g1s[HW-1:LW]);
      g3s   = HW'(fin_ff[3]) + HW'(g2s[HW-1:LW]);
      g4s   = HW'(fin_ff[4]) + HW'(g3s[HW-1:LW]);
      g4    = g4s - HW'(1 << LW);
      use_g = |g4s[HW-1:LW];
      if (use_g) begin
         sel[0] = AW'(g0s[LW-1:0]);
         sel[1] = AW'(g1s[LW-1:0]);
         sel[2] = AW'(g2s[LW-1:0]);
         sel[3] = AW'(g3s[LW-1:0]);
         sel[4] = g4[AW-1:0];
      end else begin
         for (int k = 0; k < NL; k++) begin
            sel[k] = fin_ff[k];
         end
      end
   end

   assign tsum_lo   = 65'(lo_ff) + 65'(s_low_ff);
   assign slot_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      last_in      = last_ff;
      acc_in       = acc_ff;
      h_in         = h_ff;
      dl_in        = dl_ff;
      fin_in       = fin_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      tlo_in       = tlo_ff;
      tc_in        = tc_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      mac_cmd      = '0;
      mac_cmd.a    = h_ff[col_ff];
      mac_cmd.b    = coef;

      // each row start hands back the previous row's finished limb
      if (mac_row_start) begin
         for (int k = 0; k < NL - 2; k++) begin
            dl_in[k] = dl_ff[k+1];
         end
         dl_in[NL-2] = mac_sum[LW-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               last_in = req_data.last_block;
               if (blk_skip) begin
                  state_in = ST_FCARRY;
               end else begin
                  for (int k = 0; k < NL; k++) begin
                     h_in[k] = HW'(acc_ff[k]) + HW'(m_limb[k]);
                  end
                  mac_cmd.clear = 1'b1;
                  row_in        = '0;
                  col_in        = '0;
                  state_in      = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            // issue one product per cycle, row by row
            mac_cmd.issue = 1'b1;
            mac_cmd.first = (col_ff == '0);
            if (col_ff == LAST_LIMB) begin
               col_in = '0;
               row_in = row_ff + 3'd1;
               if (row_ff == LAST_LIMB) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               col_in = col_ff + 3'd1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            acc_in[0] = AW'(fold0[LW-1:0]);
            acc_in[1] = AW'(dl_ff[1]) + AW'(fold0[KW+2:LW]);
            acc_in[2] = AW'(dl_ff[2]);
            acc_in[3] = AW'(dl_ff[3]);
            acc_in[4] = AW'(mac_sum[LW-1:0]);
            state_in  = last_ff ? ST_FCARRY : ST_IDLE;
         end
         ST_FCARRY: begin
            fin_in[0] = AW'(fc0[LW-1:0]);
            fin_in[1] = fc1;
            fin_in[2] = AW'(fc2[LW-1:0]);
            fin_in[3] = AW'(fc3[LW-1:0]);
            fin_in[4] = AW'(fc4[LW-1:0]);
            state_in  = ST_FSEL;
         end
         ST_FSEL: begin
            // pack limbs into two words; overlapping bits combine by OR
            lo_in = 64'(sel[0]) | (64'(sel[1]) << 26) | (64'(sel[2]) << 52);
            hi_in = (64'(sel[2]) >> 12) | (64'(sel[3]) << 14) | (64'(sel[4]) << 40);
            state_in = ST_FLO;
         end
         ST_FLO: begin
            tlo_in   = tsum_lo[63:0];
            tc_in    = tsum_lo[64];
            state_in = ST_FHI;
         end
         ST_FHI: begin
            // hold until the output register can take the tag
            if (slot_free) begin
               rsp_in.tag_low  = tlo_ff;
               rsp_in.tag_high = hi_ff + s_high_ff + 64'(tc_ff);
               rsp_valid_in    = 1'b1;
               for (int k = 0; k < NL; k++) begin
                  acc_in[k] = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         r_low_ff     <= '0;
         r_high_ff    <= '0;
         s_low_ff     <= '0;
         s_high_ff    <= '0;
         for (int k = 0; k < NL; k++) begin
            acc_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         r_low_ff     <= r_low_in;
         r_high_ff    <= r_high_in;
         s_low_ff     <= s_low_in;
         s_high_ff    <= s_high_in;
         acc_ff       <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff  <= row_in;
      col_ff  <= col_in;
      last_ff <= last_in;
      h_ff    <= h_in;
      dl_ff   <= dl_in;
      fin_ff  <= fin_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      tlo_ff  <= tlo_in;
      tc_ff   <= tc_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/p1305_mac.sv @@
module p1305_mac (
   input  logic                          clock,
   input  logic                          reset,
   input  p1305_pkg::mac_cmd_type        cmd,
   output logic [p1305_pkg::SUM_W-1:0]   sum,
   output logic                          row_start
);

   logic [p1305_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic                         valid_ff, valid_in;
   logic                         first_ff, first_in;
   logic [p1305_pkg::SUM_W-1:0]  sum_ff, sum_in;

   always_comb begin
      prod_in  = p1305_pkg::PROD_W'(cmd.a) * p1305_pkg::PROD_W'(cmd.b);
      valid_in = cmd.issue;
      first_in = cmd.first;
      sum_in   = sum_ff;
      priority if (cmd.clear) begin
         sum_in = '0;
      end else if (valid_ff) begin
         // first product of a row absorbs the carry out of the previous row
         if (first_ff) begin
            sum_in = (sum_ff >> p1305_pkg::LIMB_W) + p1305_pkg::SUM_W'(prod_ff);
         end else begin
            sum_in = sum_ff + p1305_pkg::SUM_W'(prod_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      first_ff <= first_in;
      sum_ff   <= sum_in;
   end

   assign sum       = sum_ff;
   assign row_start = valid_ff & first_ff;

endmodule

@@ verif/poly1305_mac_accumulator_top_test.sv @@
`timescale 1ns / 100ps

module poly1305_mac_accumulator_top_test;
   import p1305_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   // Wait long enough for a last block to finish in the block, with margin.
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_BLOCKS = 200;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam logic [63:0] ONES = 64'hffffffffffffffff;
   localparam logic [63:0] LIMB_MASK = 64'h3ffffff;

   // Clock, reset and every DUT input start at a known value.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   poly1305_mac_accumulator_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the key registers and of the accumulator.
   logic [63:0] key_r_low = '0;
   logic [63:0] key_r_high = '0;
   logic [63:0] key_s_low = '0;
   logic [63:0] key_s_high = '0;
   logic [26:0] acc_limb [5] = '{default: '0};

   // Tags still owed by the DUT, oldest first.
   rsp_type pending_tags [$];

   int error_count = 0;
   int blocks_sent = 0;
   int tags_checked = 0;
   int key_writes = 0;
   int cycle_count = 0;
   int hold_cycles = 0;
   bit long_hold_done = 1'b0;
   // Set for the closing phase: no idling on either side.
   bit calm = 1'b0;

   // -------------------------------------------------------------------------
   // Tag prediction: radix 2^26 arithmetic mod 2^130 - 5
   // -------------------------------------------------------------------------

   function automatic logic [4:0][25:0] split_limbs26(input logic [63:0] lo,
                                                      input logic [63:0] hi);
      logic [4:0][25:0] l;
      l[0] = lo[25:0];
      l[1] = lo[51:26];
      l[2] = {hi[13:0], lo[63:52]};
      l[3] = hi[39:14];
      l[4] = {2'b00, hi[63:40]};
      return l;
   endfunction

   // Add one block to the accumulator and multiply by the clamped r.
   function automatic void absorb_block(input logic [63:0] lo, input logic [63:0] hi,
                                        input bit full);
      logic [4:0][25:0] rl;
      logic [4:0][25:0] ml;
      logic [63:0] hv [5];
      logic [63:0] dv [5];
      logic [63:0] coef;
      logic [63:0] c;
      rl = split_limbs26(key_r_low & R_CLAMP_LOW, key_r_high & R_CLAMP_HIGH);
      ml = split_limbs26(lo, hi);
      if (full) ml[4][24] = 1'b1;
      for (int i = 0; i < NLIMB; i++) hv[i] = 64'(acc_limb[i]) + 64'(ml[i]);
      // Schoolbook product; terms that wrap past limb 4 fold back times 5.
      for (int i = 0; i < NLIMB; i++) begin
         dv[i] = '0;
         for (int j = 0; j < NLIMB; j++) begin
            coef = 64'(rl[(i + NLIMB - j) % NLIMB]);
            if (j > i) coef = coef * 5;
            dv[i] = dv[i] + hv[j] * coef;
         end
      end
      c = '0;
      for (int i = 0; i < NLIMB; i++) begin
         dv[i] = dv[i] + c;
         c = dv[i] >> 26;
         hv[i] = dv[i] & LIMB_MASK;
      end
      hv[0] = hv[0] + c * 5;
      c = hv[0] >> 26;
      hv[0] = hv[0] & LIMB_MASK;
      hv[1] = hv[1] + c;
      for (int i = 0; i < NLIMB; i++) acc_limb[i] = hv[i][26:0];
   endfunction

   // Fully reduce the accumulator and add s mod 2^128.
   function automatic rsp_type reduce_to_tag();
      logic [31:0] h [5];
      logic [31:0] g [5];
      logic [31:0] c;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] sum;
      rsp_type tag;
      for (int i = 0; i < NLIMB; i++) h[i] = 32'(acc_limb[i]);
      for (int i = 1; i < 4; i++) begin
         c = h[i] >> 26;
         h[i] = h[i] & 32'h3ffffff;
         h[i+1] = h[i+1] + c;
      end
      c = h[4] >> 26;
      h[4] = h[4] & 32'h3ffffff;
      h[0] = h[0] + c * 5;
      c = h[0] >> 26;
      h[0] = h[0] & 32'h3ffffff;
      h[1] = h[1] + c;
      // Trial subtraction of p; keep it unless it went negative.
      g[0] = h[0] + 5;
      c = g[0] >> 26;
      g[0] = g[0] & 32'h3ffffff;
      for (int i = 1; i < 4; i++) begin
         g[i] = h[i] + c;
         c = g[i] >> 26;
         g[i] = g[i] & 32'h3ffffff;
      end
      g[4] = h[4] + c - 32'h4000000;
      if (!g[4][31]) begin
         for (int i = 0; i < NLIMB; i++) h[i] = g[i];
      end
      lo = 64'(h[0]) | (64'(h[1]) << 26) | (64'(h[2]) << 52);
      hi = (64'(h[2]) >> 12) | (64'(h[3]) << 14) | (64'(h[4]) << 40);
      sum = lo + key_s_low;
      hi = hi + key_s_high + ((sum < lo) ? 64'd1 : 64'd0);
      tag.tag_low = sum;
      tag.tag_high = hi;
      return tag;
   endfunction

   // Advance the shadow state by one block; return 1 with the tag on a last block.
   function automatic bit absorb_and_tag(input req_type blk, output rsp_type tag);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] marker;
      logic [4:0] n;
      lo = blk.message_low;
      hi = blk.message_high;
      n = blk.byte_count;
      tag = '0;
      if (!blk.last_block) begin
         absorb_block(lo, hi, 1'b1);
         return 1'b0;
      end
      if (n >= 5'd16) begin
         absorb_block(lo, hi, 1'b1);
      end else if (n != 5'd0) begin
         // Pad: 0x01 at byte n, zeros above it, no 2^128 bit.
         if (n < 5'd8) begin
            marker = 64'd1 << (8 * n);
            lo = (lo & (marker - 1)) | marker;
            hi = '0;
         end else begin
            marker = 64'd1 << (8 * (n - 8));
            hi = (hi & (marker - 1)) | marker;
         end
         absorb_block(lo, hi, 1'b0);
      end
      tag = reduce_to_tag();
      for (int i = 0; i < NLIMB; i++) acc_limb[i] = '0;
      return 1'b1;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers: every task is entered and left at a rising edge
   // -------------------------------------------------------------------------

   // Drop valid and hold the input channel quiet for a span set by n.
   task automatic idle_for(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic maybe_gap();
      if (!calm && $urandom_range(0, 7) == 0) idle_for($urandom_range(1, 4));
   endtask

   // Offer one block and wait for its transfer. Valid stays high afterwards so
   // that a following block can go out back to back.
   task automatic send_block(input req_type blk, input bit typed, input rsp_type typed_tag);
      rsp_type tag;
      req_valid <= 1'b1;
      req_data <= blk;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
      blocks_sent++;
      if (absorb_and_tag(blk, tag)) begin
         // Rows with a hand-computed tag take that value instead.
         if (typed) tag = typed_tag;
         pending_tags.push_back(tag);
      end
   endtask

   // Setup phase, access phase, then a quiet wait so the next setup starts fresh.
   task automatic write_reg(input logic [1:0] index, input logic [63:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 3'b000};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      key_writes++;
      @(posedge clock);
   endtask

   // Drain the block, let any non-final block finish, then load a new key.
   task automatic write_keys(input logic [63:0] r_low, input logic [63:0] r_high,
                             input logic [63:0] s_low, input logic [63:0] s_high);
      req_valid <= 1'b0;
      while (pending_tags.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_reg(REG_R_LOW, r_low);
      key_r_low = r_low;
      write_reg(REG_R_HIGH, r_high);
      key_r_high = r_high;
      write_reg(REG_S_LOW, s_low);
      key_s_low = s_low;
      write_reg(REG_S_HIGH, s_high);
      key_s_high = s_high;
   endtask

   function automatic logic [63:0] random_word();
      case ($urandom_range(0, 7))
         0: return ONES;
         1: return '0;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Mostly full or padded final blocks, with empty and oversized counts mixed in.
   function automatic logic [4:0] final_count();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 5'd16;
         4: return 5'd0;
         5: return 5'($urandom_range(17, 31));
         default: return 5'($urandom_range(1, 15));
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Directed plan
   // -------------------------------------------------------------------------

   typedef struct packed {
      logic [63:0] lo;
      logic [63:0] hi;
      logic [4:0] count;
      logic last;
      logic [1:0] key_set;
      logic typed;
      logic [63:0] tag_lo;
      logic [63:0] tag_hi;
   } plan_row_type;

   localparam int PLAN_ROWS = 23;
   plan_row_type block_plan [PLAN_ROWS];
   // Key sets in order r_low, r_high, s_low, s_high. Set 0 is the reset state.
   logic [63:0] key_sets [4][4];

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------

   initial begin
      req_type blk;
      rsp_type typed_tag;
      int current_set;
      int sent;
      int chain;
      int phase;
      logic [63:0] key_word [4];

      key_sets = '{
         '{64'h0, 64'h0, 64'h0, 64'h0},
         '{ONES, ONES, ONES, ONES},
         '{64'h0, 64'h0, 64'h0123456789abcdef, 64'hfedcba9876543210},
         '{64'h1, 64'h0, 64'h0, 64'h0}
      };
      block_plan = '{
         // reset keys: r is zero, so every tag is zero
         '{64'h0, 64'h0, 5'd0, 1'b1, 2'd0, 1'b1, 64'h0, 64'h0},
         '{ONES, ONES, 5'd16, 1'b0, 2'd0, 1'b0, 64'h0, 64'h0},
         '{ONES, ONES, 5'd16, 1'b1, 2'd0, 1'b1, 64'h0, 64'h0},
         // widest clamped r and all-ones s; count ignored on non-final blocks
         '{ONES, ONES, 5'd5, 1'b0, 2'd1, 1'b0, 64'h0, 64'h0},
         '{64'h0, 64'h0, 5'd31, 1'b0, 2'd1, 1'b0, 64'h0, 64'h0},
         '{ONES, ONES, 5'd16, 1'b1, 2'd1, 1'b0, 64'h0, 64'h0},
         '{ONES, ONES, 5'd1, 1'b1, 2'd1, 1'b0, 64'h0, 64'h0},
         '{ONES, ONES, 5'd7, 1'b1, 2'd1, 1'b0, 64'h0, 64'h0},
         '{ONES, ONES, 5'd8, 1'b1, 2'd1, 1'b0, 64'h0, 64'h0},
         '{ONES, ONES, 5'd9, 1'b1, 2'd1, 1'b0, 64'h0, 64'h0},
         '{ONES, ONES, 5'd15, 1'b1, 2'd1, 1'b0, 64'h0, 64'h0},
         '{64'h8000000000000001, 64'h8000000000000001, 5'd31, 1'b1, 2'd1, 1'b0,
           64'h0, 64'h0},
         '{ONES, ONES, 5'd17, 1'b1, 2'd1, 1'b0, 64'h0, 64'h0},
         '{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd16, 1'b0, 2'd1, 1'b0,
           64'h0, 64'h0},
         // empty final block: tag from the accumulator as it stands
         '{ONES, ONES, 5'd0, 1'b1, 2'd1, 1'b0, 64'h0, 64'h0},
         // r zero: the tag is s
         '{ONES, ONES, 5'd16, 1'b0, 2'd2, 1'b0, 64'h0, 64'h0},
         '{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 5'd5, 1'b1, 2'd2, 1'b1,
           64'h0123456789abcdef, 64'hfedcba9876543210},
         // r one: two full all-ones blocks sum to 2^130 - 2, which is 3 mod p
         '{ONES, ONES, 5'd16, 1'b0, 2'd3, 1'b0, 64'h0, 64'h0},
         '{ONES, ONES, 5'd16, 1'b1, 2'd3, 1'b1, 64'h3, 64'h0},
         // accumulator lands exactly on p and reduces to zero
         '{ONES, ONES, 5'd16, 1'b0, 2'd3, 1'b0, 64'h0, 64'h0},
         '{64'hfffffffffffffffc, ONES, 5'd16, 1'b1, 2'd3, 1'b1, 64'h0, 64'h0},
         // 2^129 - 1 left as is, tag keeps only its low 128 bits
         '{ONES, ONES, 5'd16, 1'b0, 2'd3, 1'b0, 64'h0, 64'h0},
         '{64'h0, 64'h0, 5'd0, 1'b1, 2'd3, 1'b1, ONES, ONES}
      };

      // Hold reset, then release it once.
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed plan; reload keys whenever the set changes.
      current_set = 0;
      foreach (block_plan[i]) begin
         if (block_plan[i].key_set != current_set) begin
            current_set = block_plan[i].key_set;
            write_keys(key_sets[current_set][0], key_sets[current_set][1],
                       key_sets[current_set][2], key_sets[current_set][3]);
         end
         blk.message_low = block_plan[i].lo;
         blk.message_high = block_plan[i].hi;
         blk.byte_count = block_plan[i].count;
         blk.last_block = block_plan[i].last;
         typed_tag.tag_low = block_plan[i].tag_lo;
         typed_tag.tag_high = block_plan[i].tag_hi;
         maybe_gap();
         send_block(blk, block_plan[i].typed, typed_tag);
      end

      // Random messages in phases, each under its own key. The first phases use
      // extreme keys; the last phase runs without idling on either side.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: key_word = '{ONES, ONES, ONES, ONES};
            1: key_word = '{64'h0, 64'h0, 64'h0, 64'h0};
            2: key_word = '{ONES, ONES, 64'h0, 64'h0};
            default: key_word = '{random_word(), random_word(), random_word(),
                                  random_word()};
         endcase
         // The pause before each key load waits out every owed tag.
         write_keys(key_word[0], key_word[1], key_word[2], key_word[3]);
         if (phase == RANDOM_PHASES - 1) calm = 1'b1;
         sent = 0;
         while (sent < PHASE_BLOCKS) begin
            chain = $urandom_range(0, 5);
            for (int k = 0; k <= chain; k++) begin
               blk.message_low = random_word();
               blk.message_high = random_word();
               blk.last_block = (k == chain);
               blk.byte_count = blk.last_block ? final_count() : 5'($urandom_range(0, 31));
               maybe_gap();
               send_block(blk, 1'b0, '0);
               sent++;
            end
         end
         // Leave a message open across the key change now and then.
         if (phase < RANDOM_PHASES - 1 && $urandom_range(0, 1) == 1) begin
            blk.message_low = random_word();
            blk.message_high = random_word();
            blk.byte_count = 5'($urandom_range(0, 31));
            blk.last_block = 1'b0;
            send_block(blk, 1'b0, '0);
         end
      end

      // Close out: drop valid, drain, let the pipeline settle.
      req_valid <= 1'b0;
      while (pending_tags.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d blocks and %0d tags over %0d key register writes",
               blocks_sent, tags_checked, key_writes);
      $display("  padded, empty and oversized final blocks, extreme keys, reduction at p");
      if (error_count == 0) begin
         $display("poly1305_mac_accumulator_top_test: done, clean");
      end else begin
         $display("poly1305_mac_accumulator_top_test: done, errors");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // Result side: check each tag transfer, drive rsp_ready with stall bursts
   // -------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_tags.size() == 0) begin
               $error("tag transfer with no tag expected: %h %h",
                      rsp_data.tag_low, rsp_data.tag_high);
               error_count++;
            end else begin
               if (rsp_data.tag_low !== pending_tags[0].tag_low) begin
                  $error("tag_low: expected %h, got %h",
                         pending_tags[0].tag_low, rsp_data.tag_low);
                  error_count++;
               end
               if (rsp_data.tag_high !== pending_tags[0].tag_high) begin
                  $error("tag_high: expected %h, got %h",
                         pending_tags[0].tag_high, rsp_data.tag_high);
                  error_count++;
               end
               void'(pending_tags.pop_front());
               tags_checked++;
            end
         end
         // Once, while the sender is offering, hold off long enough for the
         // block to fill up and stall its input.
         if (!long_hold_done && tags_checked >= 60 && req_valid) begin
            hold_cycles = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (calm) begin
            rsp_ready <= 1'b1;
         end else if ($urandom_range(0, 5) == 0) begin
            // stall burst: drop ready now and keep it low while hold_cycles counts down
            hold_cycles = $urandom_range(0, 3);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run if it hangs.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("poly1305_mac_accumulator_top_test: done, errors");
      $finish;
   end

endmodule
